// ===== src/ip_fragment_tracker_core_macros.svh =====
// Assertion macros for the fragment tracker core.
`ifndef IP_FRAGMENT_TRACKER_CORE_MACROS_SVH
`define IP_FRAGMENT_TRACKER_CORE_MACROS_SVH

// check under reset disable
`define IFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ip_fragment_tracker_core: check failed");

// check at every edge, reset included
`define IFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ip_fragment_tracker_core: check failed");

`endif

// ===== src/ift_pkg.sv =====
// Shared types and constants of the fragment tracker core.
package ift_pkg;

  localparam int unsigned TABLE_ENTRIES   = 64;
  localparam int unsigned FRAGS_PER_ENTRY = 16;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned FCNT_W = $clog2(FRAGS_PER_ENTRY + 1);
  localparam int unsigned IN_W   = 160;
  localparam int unsigned OUT_W  = 104;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TBL_FULL  = 2'd1;
  localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

  typedef struct packed {
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [15:0]       id;
    logic [7:0]        proto;
    logic [FCNT_W-1:0] nfrags;
    logic [15:0]       covered;
    logic [15:0]       dgram_len;
    logic [31:0]       stamp;
    logic              done;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } ctrl_cmd_t;

endpackage

// ===== src/ift_ctrl.sv =====
// Sequencer of the fragment tracker: accept, table walk, commit.
module ift_ctrl import ift_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
  assign cmd_o.rd_addr = cnt_q[IDX_W-1:0];
  assign cmd_o.commit  = (state_q == ST_COMMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt_q == CNT_W'(TABLE_ENTRIES)) state_q <= ST_COMMIT;
          else cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ift_datapath.sv =====
// Slot table, walk checks, entry update and counters of the fragment tracker.
module ift_datapath import ift_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [1:0]       func_i,
  input  logic [IN_W-1:0]  item_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output logic [OUT_W-1:0] result_o
);

  entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic [15:0]      timeout_q;
  logic [1:0]       func_q;
  logic [31:0]      src_q, dst_q, now_q;
  logic [15:0]      id_q, off_q, size_q;
  logic [7:0]       proto_q;
  logic             more_q;

  entry_t           rd_q;
  logic             chk_q;
  logic [IDX_W-1:0] chk_addr_q;

  logic             hit_q, free_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q;
  entry_t           hit_e_q;

  logic [31:0]      reas_q, drop_q, exp_q;
  logic [31:0]      reas_d, drop_d;
  logic [OUT_W-1:0] result_q;

  logic        v, expire, match, is_add;
  logic [31:0] idle;

  entry_t           base_e, new_e;
  logic [IDX_W-1:0] k;
  logic             have_k, list_full, complete_ev;
  logic [1:0]       status;
  logic             complete;

  assign is_add = (func_q == FUNC_ADD);
  assign v      = valid_q[chk_addr_q];
  assign idle   = now_q - rd_q.stamp;
  assign expire = is_add && v && (idle > {16'd0, timeout_q});
  assign match  = v && !expire && rd_q.src == src_q && rd_q.dst == dst_q &&
                  rd_q.id == id_q && rd_q.proto == proto_q;

  always_comb begin
    base_e            = hit_e_q;
    k                 = hit_idx_q;
    have_k            = hit_q || free_q;
    if (!hit_q) begin
      k                 = free_idx_q;
      base_e.src        = src_q;
      base_e.dst        = dst_q;
      base_e.id         = id_q;
      base_e.proto      = proto_q;
      base_e.nfrags     = '0;
      base_e.covered    = '0;
      base_e.dgram_len  = '0;
      base_e.stamp      = now_q;
      base_e.done       = 1'b0;
    end
    list_full          = base_e.nfrags >= FCNT_W'(FRAGS_PER_ENTRY);
    new_e              = base_e;
    new_e.nfrags       = base_e.nfrags + FCNT_W'(1);
    new_e.covered      = base_e.covered + size_q;
    new_e.stamp        = now_q;
    if (!more_q) new_e.dgram_len = off_q + size_q;
    complete_ev        = (new_e.dgram_len != 16'd0) && (new_e.covered >= new_e.dgram_len);
    if (complete_ev) new_e.done = 1'b1;
    status   = STATUS_OK;
    complete = 1'b0;
    reas_d   = reas_q;
    drop_d   = drop_q;
    if (is_add) begin
      if (!have_k) status = STATUS_TBL_FULL;
      else if (list_full) status = STATUS_LIST_FULL;
      if (!have_k || list_full) drop_d = drop_q + 32'd1;
      else if (complete_ev) reas_d = reas_q + 32'd1;
    end else if (func_q == FUNC_QUERY) begin
      complete = hit_q && hit_e_q.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[cmd_i.rd_addr];
    if (cmd_i.commit && is_add && have_k && !list_full) mem[k] <= new_e;
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= cmd_i.rd_addr;
    if (cmd_i.load) begin
      func_q  <= func_i;
      src_q   <= item_i[31:0];
      dst_q   <= item_i[63:32];
      id_q    <= item_i[79:64];
      proto_q <= item_i[87:80];
      off_q   <= item_i[103:88];
      size_q  <= item_i[119:104];
      more_q  <= item_i[120];
      now_q   <= item_i[152:121];
    end
    if (chk_q && match && !hit_q) begin
      hit_idx_q <= chk_addr_q;
      hit_e_q   <= rd_q;
    end
    if (chk_q && (!v || expire) && !free_q) free_idx_q <= chk_addr_q;
    if (cmd_i.commit) result_q <= {5'd0, exp_q, drop_d, reas_d, complete, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      timeout_q <= TIMEOUT_RESET;
      chk_q     <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      reas_q    <= '0;
      drop_q    <= '0;
      exp_q     <= '0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      chk_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (chk_q) begin
        if (match) hit_q <= 1'b1;
        if (!v || expire) free_q <= 1'b1;
        if (expire) begin
          valid_q[chk_addr_q] <= 1'b0;
          if (!rd_q.done) exp_q <= exp_q + 32'd1;
        end
      end
      if (cmd_i.commit) begin
        reas_q <= reas_d;
        drop_q <= drop_d;
        if (is_add) begin
          if (have_k && !list_full) valid_q[k] <= 1'b1;
        end else if (func_q == FUNC_REMOVE && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
        end
      end
    end
  end

  assign result_o = result_q;

endmodule

// ===== src/ip_fragment_tracker_core.sv =====
// Top level of the IPv4 fragment reassembly tracker.
// Requests arrive on the s_axis channel: tuser carries the operation (add,
// query, remove), tdata the datagram key, fragment offset, size, more flag
// and current time. Each request yields one result transfer on m_axis with
// status, completion flag and the three wrapping event counters.
// A request walks all TABLE_ENTRIES slots through one memory read port, one
// slot per cycle; adds expire idle entries during that walk. The result is
// registered once the walk is done and the output register is free, and the
// next request is taken the cycle after that. s_axis_tready is high only
// between requests. A stalled result holds in the output register; the next
// request may be taken and walked meanwhile, and its commit waits until the
// held result is taken. The user must write the timeout register through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
// Reset clears all slot valid bits, the counters and sets the timeout to 30.
`include "ip_fragment_tracker_core_macros.svh"
module ip_fragment_tracker_core import ift_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // src_addr, dst_addr, datagram_id, protocol_number, fragment_offset,
  // fragment_size, more_fragments, current_time
  input  logic [IN_W-1:0]  s_axis_tdata,
  // func
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, is_complete, reassembled_total, dropped_total, expired_total
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);

  ctrl_cmd_t cmd;

  ift_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ift_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (s_axis_tuser),
    .item_i      (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (m_axis_tdata)
  );

  `IFT_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `IFT_ASSERT(a_commit_shows_result, cmd.commit |=> m_axis_tvalid)
  `IFT_ASSERT(a_commit_out_free, cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
  `IFT_ASSERT_ALWAYS(a_no_load_and_read, !(cmd.load && cmd.rd_en))

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the IPv4 fragment tracker core.
`timescale 1ns / 100ps
module tb_top;
  import ift_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] id;
    logic [7:0]  proto;
    logic [15:0] off;
    logic [15:0] size;
    logic        more;
    logic [31:0] now;
  } frag_req_t;

  typedef struct {
    logic [1:0]  status;
    logic        complete;
    logic [31:0] reasm;
    logic [31:0] dropped;
    logic [31:0] expired;
  } tally_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_valid;
  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic             m_ready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we;
  logic [15:0]      cfg_wdata;
  frag_req_t        cur;
  logic [IN_W-1:0]  in_data;

  frag_req_t pend_q[$];
  tally_t    tally_q[$];
  int        tx_gap, rx_gap, hold_left;
  bit        xfer_done, quiet, failed;
  int        n_checked, n_sent;

  // predictor state
  logic [15:0] p_timeout;
  bit          p_valid[TABLE_ENTRIES];
  logic [31:0] p_src[TABLE_ENTRIES];
  logic [31:0] p_dst[TABLE_ENTRIES];
  logic [15:0] p_id[TABLE_ENTRIES];
  logic [7:0]  p_proto[TABLE_ENTRIES];
  int          p_fcount[TABLE_ENTRIES];
  logic [15:0] p_covered[TABLE_ENTRIES];
  logic [15:0] p_total[TABLE_ENTRIES];
  logic [31:0] p_seen[TABLE_ENTRIES];
  bit          p_done[TABLE_ENTRIES];
  logic [31:0] p_reasm, p_dropped, p_expired;

  // stimulus state
  logic [31:0] t_now;
  logic [31:0] k_src[8];
  logic [31:0] k_dst[8];
  logic [15:0] k_id[8];
  logic [7:0]  k_proto[8];
  logic [15:0] k_next[8];

  assign in_data = {7'd0, cur.now, cur.more, cur.size, cur.off, cur.proto, cur.id,
                    cur.dst, cur.src};

  ip_fragment_tracker_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(in_data), .s_axis_tuser(cur.func),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0; #6;
    clk_i = 1'b1; #6;
  end

  function automatic int find_slot(frag_req_t r);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (p_valid[i] && p_src[i] == r.src && p_dst[i] == r.dst && p_id[i] == r.id &&
          p_proto[i] == r.proto)
        return i;
    return -1;
  endfunction

  task automatic track_fragment(frag_req_t r);
    tally_t      t;
    int          k;
    logic [31:0] idle;
    t.status = STATUS_OK;
    t.complete = 1'b0;
    if (r.func == FUNC_ADD) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        idle = r.now - p_seen[i];
        if (p_valid[i] && idle > {16'd0, p_timeout}) begin
          if (!p_done[i]) p_expired++;
          p_valid[i] = 0;
        end
      end
      k = find_slot(r);
      if (k < 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (!p_valid[i] && k < 0) k = i;
        if (k < 0) begin
          p_dropped++;
          t.status = STATUS_TBL_FULL;
        end else begin
          p_valid[k] = 1; p_src[k] = r.src; p_dst[k] = r.dst; p_id[k] = r.id;
          p_proto[k] = r.proto; p_fcount[k] = 0; p_covered[k] = '0; p_total[k] = '0;
          p_seen[k] = r.now; p_done[k] = 0;
        end
      end
      if (k >= 0) begin
        if (p_fcount[k] >= FRAGS_PER_ENTRY) begin
          p_dropped++;
          t.status = STATUS_LIST_FULL;
        end else begin
          p_fcount[k]++;
          p_covered[k] = p_covered[k] + r.size;
          p_seen[k] = r.now;
          if (!r.more) p_total[k] = r.off + r.size;
          if (p_total[k] != 16'd0 && p_covered[k] >= p_total[k]) begin
            p_done[k] = 1;
            p_reasm++;
          end
        end
      end
    end else if (r.func == FUNC_QUERY) begin
      k = find_slot(r);
      if (k >= 0 && p_done[k]) t.complete = 1'b1;
    end else if (r.func == FUNC_REMOVE) begin
      k = find_slot(r);
      if (k >= 0) p_valid[k] = 0;
    end
    t.reasm = p_reasm;
    t.dropped = p_dropped;
    t.expired = p_expired;
    tally_q.push_back(t);
  endtask

  // sample both handshakes
  always @(posedge clk_i) begin : mon
    tally_t e;
    tally_t a;
    if (rst_ni && s_valid && s_axis_tready) begin
      track_fragment(cur);
      n_sent++;
      xfer_done = 1;
    end
    if (rst_ni && m_axis_tvalid && m_ready) begin
      a.status = m_axis_tdata[1:0];
      a.complete = m_axis_tdata[2];
      a.reasm = m_axis_tdata[34:3];
      a.dropped = m_axis_tdata[66:35];
      a.expired = m_axis_tdata[98:67];
      if (tally_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        failed = 1;
      end else begin
        e = tally_q.pop_front();
        n_checked++;
        if (a.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, a.status); failed = 1;
        end
        if (a.complete !== e.complete) begin
          $display("%0t: complete exp %0d got %0d", $time, e.complete, a.complete);
          failed = 1;
        end
        if (a.reasm !== e.reasm) begin
          $display("%0t: reassembled exp %0d got %0d", $time, e.reasm, a.reasm); failed = 1;
        end
        if (a.dropped !== e.dropped) begin
          $display("%0t: dropped exp %0d got %0d", $time, e.dropped, a.dropped); failed = 1;
        end
        if (a.expired !== e.expired) begin
          $display("%0t: expired exp %0d got %0d", $time, e.expired, a.expired); failed = 1;
        end
      end
    end
  end

  always @(negedge clk_i) begin : drv
    bit        nv;
    frag_req_t ni;
    nv = s_valid;
    ni = cur;
    if (!s_valid || xfer_done) begin
      xfer_done = 0;
      if (tx_gap > 0) begin
        tx_gap--;
        nv = 0;
      end else if (pend_q.size() > 0) begin
        ni = pend_q.pop_front();
        nv = 1;
        if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 5);
      end else begin
        nv = 0;
      end
    end
    s_valid <= nv;
    cur <= ni;
  end

  always @(negedge clk_i) begin : rcv
    bit r;
    if (hold_left > 0) begin
      hold_left--;
      r = 0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      r = 0;
    end else begin
      r = 1;
      if (!quiet && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 5);
    end
    m_ready <= r;
  end

  function automatic frag_req_t make_req(logic [1:0] f, int key, logic [15:0] off,
                                         logic [15:0] size, logic more);
    frag_req_t r;
    r.func = f; r.src = k_src[key]; r.dst = k_dst[key]; r.id = k_id[key];
    r.proto = k_proto[key]; r.off = off; r.size = size; r.more = more; r.now = t_now;
    return r;
  endfunction

  task automatic new_keys();
    for (int i = 0; i < 8; i++) begin
      k_src[i] = $urandom; k_dst[i] = $urandom; k_id[i] = 16'($urandom);
      k_proto[i] = 8'($urandom); k_next[i] = '0;
    end
  endtask

  task automatic random_items(int n);
    frag_req_t r;
    int        key, pick;
    logic [15:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      key = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) t_now = t_now + $urandom_range(0, 70000);
      else if ($urandom_range(0, 99) == 0) t_now = $urandom;
      else t_now = t_now + $urandom_range(0, 3);
      if (pick < 70) begin
        sz = 16'($urandom_range(0, 1500));
        r = make_req(FUNC_ADD, key, k_next[key], sz, $urandom_range(0, 3) != 0);
        k_next[key] = k_next[key] + sz;
        if (!r.more) k_next[key] = '0;
      end else if (pick < 82) begin
        r = make_req(FUNC_QUERY, key, 16'($urandom), 16'($urandom), 1'($urandom));
      end else if (pick < 89) begin
        r = make_req(FUNC_REMOVE, key, 16'($urandom), 16'($urandom), 1'($urandom));
        k_next[key] = '0;
      end else if (pick < 92) begin
        r = make_req(FUNC_RSVD, key, 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        r.func = ($urandom_range(0, 3) == 0) ? FUNC_QUERY : FUNC_ADD;
        r.src = $urandom; r.dst = $urandom; r.id = 16'($urandom); r.proto = 8'($urandom);
        r.off = 16'($urandom); r.size = 16'($urandom); r.more = 1'($urandom);
        r.now = t_now;
      end
      if ($urandom_range(0, 19) == 0) new_keys();
      pend_q.push_back(r);
    end
  endtask

  task automatic drain_and_write(logic [15:0] value);
    while (pend_q.size() > 0 || s_valid || tally_q.size() > 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    p_timeout = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    s_valid = 0; m_ready = 0; cfg_we = 0; cfg_wdata = '0;
    cur = '{default: '0};
    rst_ni = 0;
    tx_gap = 0; rx_gap = 0; hold_left = 0; xfer_done = 0; quiet = 0; failed = 0;
    n_checked = 0; n_sent = 0;
    p_timeout = TIMEOUT_RESET;
    p_reasm = 0; p_dropped = 0; p_expired = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      p_valid[i] = 0; p_seen[i] = '0;
    end
    t_now = 32'hFFFF_FFF0;
    new_keys();
    repeat (3) @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes, every operation, zero total, list full, time wrap
    pend_q.push_back(make_req(FUNC_QUERY, 0, 16'd0, 16'd0, 1'b1));
    pend_q.push_back(make_req(FUNC_ADD, 0, 16'd0, 16'd100, 1'b1));
    pend_q.push_back(make_req(FUNC_ADD, 0, 16'd100, 16'd50, 1'b0));
    pend_q.push_back(make_req(FUNC_QUERY, 0, 16'd0, 16'd0, 1'b0));
    pend_q.push_back(make_req(FUNC_ADD, 0, 16'd0, 16'd1, 1'b1));
    pend_q.push_back(make_req(FUNC_REMOVE, 0, 16'd0, 16'd0, 1'b0));
    pend_q.push_back(make_req(FUNC_REMOVE, 0, 16'd0, 16'd0, 1'b0));
    pend_q.push_back(make_req(FUNC_ADD, 1, 16'hFFFF, 16'd1, 1'b0));
    pend_q.push_back(make_req(FUNC_ADD, 1, 16'hFFFF, 16'hFFFF, 1'b1));
    pend_q.push_back(make_req(FUNC_RSVD, 1, 16'hFFFF, 16'hFFFF, 1'b1));
    for (int i = 0; i < 18; i++)
      pend_q.push_back(make_req(FUNC_ADD, 2, 16'd0, 16'd8, 1'b1));
    t_now = 32'd40;
    pend_q.push_back(make_req(FUNC_ADD, 3, 16'd0, 16'd0, 1'b0));
    pend_q.push_back(make_req(FUNC_QUERY, 2, 16'd0, 16'd0, 1'b0));

    drain_and_write(16'd0);
    random_items(250);

    drain_and_write(16'hFFFF);
    for (int i = 0; i < 70; i++) begin
      k_id[0] = 16'(i);
      pend_q.push_back(make_req(FUNC_ADD, 0, 16'd0, 16'd10, 1'b1));
    end
    @(posedge clk_i);
    hold_left = 600;
    random_items(300);

    drain_and_write(16'($urandom));
    random_items(400);

    drain_and_write(16'd5);
    random_items(250);
    while (pend_q.size() > 0) @(negedge clk_i);
    quiet = 1;
    random_items(150);

    while (pend_q.size() > 0 || s_valid || tally_q.size() > 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    $display("covered %0d requests, %0d results checked, timeouts 30/0/65535/random/5",
             n_sent, n_checked);
    $display("totals: reassembled %0d dropped %0d expired %0d", p_reasm, p_dropped, p_expired);
    if (!failed && tally_q.size() == 0) begin
      $display("ip_fragment_tracker_core: match");
    end else begin
      $display("ip_fragment_tracker_core: mismatch");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("ip_fragment_tracker_core: mismatch");
    $finish;
  end

endmodule
